@@ src/trob_pkg.sv @@
package trob_pkg;

	// default geometry
	localparam int DEPTH_DEF = 64;
	localparam int WORDS_DEF = 4;
	localparam int MAX_WORDS = 4;

	// field widths
	localparam int WORD_W  = 32;
	localparam int STAMP_W = 17;
	localparam int CNT_W   = 7;

	// queue depths between the parts
	localparam int FQ_DEPTH = 2;
	localparam int FQ_AW    = 1;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = 2;
	localparam int OQ_LW    = 3;

	// action codes
	localparam logic [2:0] ACT_PUSH   = 3'd0;
	localparam logic [2:0] ACT_READ   = 3'd1;
	localparam logic [2:0] ACT_NEWEST = 3'd2;
	localparam logic [2:0] ACT_COUNT  = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0]        action;
		logic [WORD_W-1:0] in_word0;
		logic [WORD_W-1:0] in_word1;
		logic [WORD_W-1:0] in_word2;
		logic [WORD_W-1:0] in_word3;
		logic [2:0]        word_count;
		logic [5:0]        in_sec;
		logic [5:0]        in_min;
		logic [4:0]        in_hour;
		logic [CNT_W-1:0]  read_count;
	} in_t;

	typedef struct packed {
		logic              status;
		logic [WORD_W-1:0] out_word0;
		logic [WORD_W-1:0] out_word1;
		logic [WORD_W-1:0] out_word2;
		logic [WORD_W-1:0] out_word3;
		logic [5:0]        out_sec;
		logic [5:0]        out_min;
		logic [4:0]        out_hour;
		logic [CNT_W-1:0]  stored_count;
		logic              last;
	} out_t;

	typedef enum logic [2:0] {
		OP_PUSH,
		OP_READ,
		OP_NEWEST,
		OP_COUNT,
		OP_CLEAR,
		OP_BAD
	} op_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t                                op;
		logic [MAX_WORDS-1:0][WORD_W-1:0]   words;
		logic [MAX_WORDS-1:0]               wmask;
		logic [STAMP_W-1:0]                 stamp;
		logic [CNT_W-1:0]                   n;
	} cmd_t;

	// result descriptor travelling beside the store read
	typedef struct packed {
		logic               valid;
		logic               status;
		logic               has_entry;
		logic               cmp;
		logic [STAMP_W-1:0] cmp_stamp;
		logic [CNT_W-1:0]   cnt;
		logic               last;
	} meta_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_STREAM
	} bstate_t;

endpackage

@@ src/trob_front.sv @@
module trob_front #(
	parameter int WORDS = trob_pkg::WORDS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  trob_pkg::in_t   request,
	output logic            cmd_valid,
	output trob_pkg::cmd_t  cmd,
	input  logic            cmd_take
);

	trob_pkg::cmd_t                  fifo_q [trob_pkg::FQ_DEPTH];
	logic [trob_pkg::FQ_AW-1:0]      wr_ptr_q;
	logic [trob_pkg::FQ_AW-1:0]      rd_ptr_q;
	logic [trob_pkg::FQ_AW:0]        count_q;
	trob_pkg::cmd_t                  cls;
	logic                            wr;
	logic                            rd;

	// classify the incoming word
	always_comb begin
		cls = '0;
		case (request.action)
			trob_pkg::ACT_PUSH:   cls.op = trob_pkg::OP_PUSH;
			trob_pkg::ACT_READ:   cls.op = trob_pkg::OP_READ;
			trob_pkg::ACT_NEWEST: cls.op = trob_pkg::OP_NEWEST;
			trob_pkg::ACT_COUNT:  cls.op = trob_pkg::OP_COUNT;
			trob_pkg::ACT_CLEAR:  cls.op = trob_pkg::OP_CLEAR;
			default:              cls.op = trob_pkg::OP_BAD;
		endcase
		cls.words[0] = request.in_word0;
		cls.words[1] = request.in_word1;
		cls.words[2] = request.in_word2;
		cls.words[3] = request.in_word3;
		// word lanes beyond the count or the ring width stay untouched
		for (int w = 0; w < trob_pkg::MAX_WORDS; w++) begin
			cls.wmask[w] = (w < WORDS) && (request.word_count > 3'(w));
		end
		cls.stamp = {request.in_hour, request.in_min, request.in_sec};
		cls.n     = request.read_count;
	end

	assign full      = (count_q == (trob_pkg::FQ_AW+1)'(trob_pkg::FQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign wr        = push && !full;
	assign rd        = cmd_valid && cmd_take;

	// command queue storage
	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wr_ptr_q] <= cls;
		end
	end

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/trob_back.sv @@
module trob_back #(
	parameter int DEPTH = trob_pkg::DEPTH_DEF,
	parameter int WORDS = trob_pkg::WORDS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  trob_pkg::cmd_t            cmd,
	output logic                      cmd_take,
	input  logic [trob_pkg::OQ_LW-1:0] oq_level,
	output logic                      res_valid,
	output trob_pkg::out_t            res
);

	localparam int PTR_W = $clog2(DEPTH);

	trob_pkg::bstate_t          state_q, state_d;
	logic [PTR_W-1:0]           wp_q, wp_d;
	logic [PTR_W-1:0]           rp_q, rp_d;
	logic                       wd_q, wd_d;
	logic                       we_q, we_d;
	logic [PTR_W-1:0]           slot_q, slot_d;
	logic [PTR_W-1:0]           remain_q, remain_d;
	logic [PTR_W-1:0]           clr_q, clr_d;
	logic [PTR_W-1:0]           raddr;
	logic [PTR_W-1:0]           waddr;
	logic                       wzero;
	logic [trob_pkg::MAX_WORDS-1:0] mem_we;
	logic                       st_we;
	logic                       room;
	logic [trob_pkg::CNT_W-1:0] cur_cnt;
	trob_pkg::meta_t            iss;
	trob_pkg::meta_t            meta_s1;

	logic [trob_pkg::MAX_WORDS-1:0][trob_pkg::WORD_W-1:0] rword;
	logic [trob_pkg::STAMP_W-1:0]   sdata_s1;
	logic [trob_pkg::STAMP_W-1:0]   rstamp;
	logic [trob_pkg::STAMP_W-1:0]   stamp_mem [DEPTH];
	logic                           differ;
	logic                           use_entry;

	function automatic logic [PTR_W-1:0] inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [trob_pkg::CNT_W-1:0] stored_f(
		input logic [PTR_W-1:0] wp,
		input logic [PTR_W-1:0] rp,
		input logic             wd
	);
		logic [PTR_W:0] top;
		top = {1'b0, wp} + (wd ? (PTR_W+1)'(DEPTH) : '0);
		return (top >= {1'b0, rp}) ? trob_pkg::CNT_W'(top - {1'b0, rp}) : '0;
	endfunction

	assign cur_cnt = stored_f(wp_q, rp_q, wd_q);
	assign room    = ({1'b0, oq_level} + {3'b000, meta_s1.valid})
		< (trob_pkg::OQ_LW+1)'(trob_pkg::OQ_DEPTH);

	// sequencer: zeroing pass after reset, then one command per cycle while the
	// out queue has room and no read streams; reads stream one entry per cycle with room
	always_comb begin
		logic [7:0] start;
		state_d  = state_q;
		wp_d     = wp_q;
		rp_d     = rp_q;
		wd_d     = wd_q;
		we_d     = we_q;
		slot_d   = slot_q;
		remain_d = remain_q;
		clr_d    = clr_q;
		raddr    = slot_q;
		waddr    = wp_q;
		wzero    = 1'b0;
		mem_we   = '0;
		st_we    = 1'b0;
		cmd_take = 1'b0;
		iss      = '0;
		start    = 8'({1'b0, wp_q}) + 8'(DEPTH) - {1'b0, cmd.n};
		if (start >= 8'(DEPTH)) begin
			start = start - 8'(DEPTH);
		end
		case (state_q)
			trob_pkg::B_CLEAR: begin
				// zero one entry of every store per cycle
				mem_we = '1;
				st_we  = 1'b1;
				wzero  = 1'b1;
				waddr  = clr_q;
				clr_d  = inc(clr_q);
				if (clr_q == PTR_W'(DEPTH - 1)) begin
					state_d = trob_pkg::B_IDLE;
				end
			end
			trob_pkg::B_IDLE: begin
				if (cmd_valid && room) begin
					cmd_take  = 1'b1;
					iss.valid = 1'b1;
					iss.last  = 1'b1;
					iss.cnt   = cur_cnt;
					case (cmd.op)
						trob_pkg::OP_PUSH: begin
							// full ring drops its oldest entry
							if (wd_q && (wp_q == rp_q)) begin
								rp_d = inc(rp_q);
							end
							mem_we = cmd.wmask;
							st_we  = 1'b1;
							wp_d   = inc(wp_q);
							if (wp_q == PTR_W'(DEPTH - 1)) begin
								wd_d = 1'b1;
								we_d = 1'b1;
							end
							iss.cnt = stored_f(wp_d, rp_d, wd_d);
						end
						trob_pkg::OP_READ: begin
							if (cmd.n > cur_cnt) begin
								iss.status = 1'b1;
							end else begin
								rp_d    = wp_q;
								wd_d    = 1'b0;
								iss.cnt = '0;
								if (cmd.n != '0) begin
									raddr         = PTR_W'(start);
									iss.has_entry = 1'b1;
									iss.last      = (cmd.n == trob_pkg::CNT_W'(1));
									if (cmd.n != trob_pkg::CNT_W'(1)) begin
										state_d  = trob_pkg::B_STREAM;
										slot_d   = inc(PTR_W'(start));
										remain_d = PTR_W'(cmd.n - 1'b1);
									end
								end
							end
						end
						trob_pkg::OP_NEWEST: begin
							if (wp_q == '0) begin
								raddr = we_q ? PTR_W'(DEPTH - 1) : '0;
							end else begin
								raddr = wp_q - 1'b1;
							end
							iss.cmp       = 1'b1;
							iss.cmp_stamp = cmd.stamp;
						end
						trob_pkg::OP_COUNT: begin
						end
						trob_pkg::OP_CLEAR: begin
							wp_d    = '0;
							rp_d    = '0;
							wd_d    = 1'b0;
							we_d    = 1'b0;
							iss.cnt = '0;
						end
						default: begin
							iss.status = 1'b1;
						end
					endcase
				end
			end
			trob_pkg::B_STREAM: begin
				if (room) begin
					raddr         = slot_q;
					iss.valid     = 1'b1;
					iss.has_entry = 1'b1;
					iss.last      = (remain_q == PTR_W'(1));
					slot_d        = inc(slot_q);
					remain_d      = remain_q - 1'b1;
					if (remain_q == PTR_W'(1)) begin
						state_d = trob_pkg::B_IDLE;
					end
				end
			end
			default: begin
				state_d = trob_pkg::B_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= trob_pkg::B_CLEAR;
			wp_q     <= '0;
			rp_q     <= '0;
			wd_q     <= 1'b0;
			we_q     <= 1'b0;
			slot_q   <= '0;
			remain_q <= '0;
			clr_q    <= '0;
			meta_s1  <= '0;
		end else begin
			state_q  <= state_d;
			wp_q     <= wp_d;
			rp_q     <= rp_d;
			wd_q     <= wd_d;
			we_q     <= we_d;
			slot_q   <= slot_d;
			remain_q <= remain_d;
			clr_q    <= clr_d;
			meta_s1  <= iss;
		end
	end

	// word lanes, one memory for each lane below WORDS
	for (genvar w = 0; w < trob_pkg::MAX_WORDS; w++) begin : g_lane
		if (w < WORDS) begin : g_used
			logic [trob_pkg::WORD_W-1:0] mem [DEPTH];
			logic [trob_pkg::WORD_W-1:0] data_s1;

			always_ff @(posedge clk) begin
				if (mem_we[w]) begin
					mem[waddr] <= wzero ? '0 : cmd.words[w];
				end
				data_s1 <= mem[raddr];
			end

			assign rword[w] = data_s1;
		end else begin : g_unused
			assign rword[w] = '0;
		end
	end

	// stamp memory
	always_ff @(posedge clk) begin
		if (st_we) begin
			stamp_mem[waddr] <= wzero ? '0 : cmd.stamp;
		end
		sdata_s1 <= stamp_mem[raddr];
	end

	// assemble the result word
	assign rstamp    = sdata_s1;
	assign differ    = (rstamp != meta_s1.cmp_stamp);
	assign use_entry = meta_s1.has_entry || (meta_s1.cmp && differ);
	assign res_valid = meta_s1.valid;

	always_comb begin
		res              = '0;
		res.status       = meta_s1.cmp ? !differ : meta_s1.status;
		res.stored_count = meta_s1.cnt;
		res.last         = meta_s1.last;
		if (use_entry) begin
			res.out_word0 = rword[0];
			res.out_word1 = rword[1];
			res.out_word2 = rword[2];
			res.out_word3 = rword[3];
			res.out_sec   = rstamp[5:0];
			res.out_min   = rstamp[11:6];
			res.out_hour  = rstamp[16:12];
		end
	end

endmodule

@@ src/trob_out_queue.sv @@
module trob_out_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr,
	input  trob_pkg::out_t             wdata,
	output logic [trob_pkg::OQ_LW-1:0] level,
	output logic                       empty,
	input  logic                       pop,
	output trob_pkg::out_t             result
);

	trob_pkg::out_t              fifo_q [trob_pkg::OQ_DEPTH];
	logic [trob_pkg::OQ_AW-1:0]  wr_ptr_q;
	logic [trob_pkg::OQ_AW-1:0]  rd_ptr_q;
	logic [trob_pkg::OQ_LW-1:0]  count_q;
	logic                        rd;

	assign level  = count_q;
	assign empty  = (count_q == '0);
	assign result = fifo_q[rd_ptr_q];
	assign rd     = pop && !empty;

	// result storage, room is reserved by the sequencer
	always_ff @(posedge clk) begin
		if (wr) begin
			fifo_q[wr_ptr_q] <= wdata;
		end
	end

	// result pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/timestamped_overwrite_ring_buffer.sv @@
// a result is registered beside the store read, then written to the out queue
// throughput: one action per cycle when the out queue has room and no read streams;
//   a read streams one entry per cycle while there is room, set by the single read
//   port of the entry store and the in-order sequencer
// reset: asynchronous, clears pointers and queues, then a zeroing pass clears all
//   stored words and stamps; words wait in the front queue until the pass ends
module timestamped_overwrite_ring_buffer #(
	parameter int DEPTH = trob_pkg::DEPTH_DEF,
	parameter int WORDS = trob_pkg::WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  trob_pkg::in_t  request,
	output logic           empty,
	input  logic           pop,
	output trob_pkg::out_t result
);

	logic                       cmd_valid;
	trob_pkg::cmd_t             cmd;
	logic                       cmd_take;
	logic [trob_pkg::OQ_LW-1:0] oq_level;
	logic                       res_valid;
	trob_pkg::out_t             res;

	// accept and classify
	trob_front #(
		.WORDS (WORDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// execute against the ring
	trob_back #(
		.DEPTH (DEPTH),
		.WORDS (WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.oq_level  (oq_level),
		.res_valid (res_valid),
		.res       (res)
	);

	// results waiting to be popped
	trob_out_queue u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_valid),
		.wdata  (res),
		.level  (oq_level),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
